// File: hw/rtl/quadrature_knob_volume_and_button_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the knob panel block
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_KNOB_VOLUME_AND_BUTTON_DEFINES_SVH
`define QUADRATURE_KNOB_VOLUME_AND_BUTTON_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clock, off during reset
`define QKVB_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("knob panel assertion failed");
// next-cycle implication
`define QKVB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("knob panel assertion failed");
`else
`define QKVB_ASSERT_IMPL(label, ante, cons)
`define QKVB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/qkvb_pkg.sv
// ----------------------------------------------------------------------------
// qkvb_pkg
// Types, codes and the quadrature step table shared by the knob panel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qkvb_pkg;

   // register indexes
   localparam logic [1:0] CSR_VOLUME_MIN  = 2'd0;
   localparam logic [1:0] CSR_VOLUME_MAX  = 2'd1;
   localparam logic [1:0] CSR_VOLUME_STEP = 2'd2;
   localparam logic [1:0] CSR_LONG_PRESS  = 2'd3;

   // knob 2 event codes
   localparam logic [1:0] EVENT_NONE = 2'd0;
   localparam logic [1:0] EVENT_CW   = 2'd1;
   localparam logic [1:0] EVENT_CCW  = 2'd2;

   // reset values
   localparam logic signed [7:0] VOLUME_MIN_RESET  = -8'sd80;
   localparam logic signed [7:0] VOLUME_MAX_RESET  = 8'sd6;
   localparam logic [4:0]        VOLUME_STEP_RESET = 5'd1;
   localparam logic [15:0]       LONG_PRESS_RESET  = 16'd350;
   localparam logic signed [7:0] VOLUME_RESET      = -8'sd20;
   localparam logic [1:0]        PHASE_RESET       = 2'b11;

   localparam int                DETENT_COUNT      = 4;
   localparam logic [15:0]       PRESS_COUNT_MAX   = 16'hFFFF;

   typedef struct packed {
      logic knob1_phase_a;
      logic knob1_phase_b;
      logic knob2_phase_a;
      logic knob2_phase_b;
      logic switch_level;
   } req_payload_type;

   typedef struct packed {
      logic              volume_changed;
      logic signed [7:0] volume_level;
      logic [1:0]        knob2_event;
      logic              long_press;
      logic              short_press;
   } rsp_payload_type;

   typedef struct packed {
      logic cw;
      logic ccw;
   } knob_dir_type;

   typedef struct packed {
      logic long_press;
      logic short_press;
   } press_type;

   // Gray-code transition table: {previous, current} -> -1, 0, +1
   function automatic logic signed [1:0] step_lut(input logic [3:0] idx);
      logic signed [1:0] val;
      unique case (idx)
         4'd1, 4'd7, 4'd8, 4'd14:  val = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: val = 2'sd1;
         default:                  val = 2'sd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qkvb_knob.sv
// ----------------------------------------------------------------------------
// qkvb_knob
// One quadrature decoder: step table, accumulator and detent detect.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qkvb_knob
   import qkvb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         update_en,
   input  wire logic [1:0]   phase,
   output knob_dir_type      dir
);

   logic [1:0]        prev_phase_ff, prev_phase_in;
   logic signed [2:0] accum_ff, accum_in;
   logic signed [3:0] sum;

   always_comb begin
      sum = 4'(accum_ff) + 4'(step_lut({prev_phase_ff, phase}));
      dir = '0;
      accum_in = sum[2:0];
      priority if (sum >= 4'(DETENT_COUNT)) begin
         dir.cw   = 1'b1;
         accum_in = '0;
      end else if (sum <= -4'(DETENT_COUNT)) begin
         dir.ccw  = 1'b1;
         accum_in = '0;
      end
      prev_phase_in = phase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_phase_ff <= PHASE_RESET;
         accum_ff      <= '0;
      end else if (update_en) begin
         prev_phase_ff <= prev_phase_in;
         accum_ff      <= accum_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/qkvb_volume.sv
// ----------------------------------------------------------------------------
// qkvb_volume
// Master volume register, stepped per detent and clamped in travel direction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qkvb_volume
   import qkvb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              update_en,
   input  wire knob_dir_type      dir,
   input  wire logic signed [7:0] volume_min,
   input  wire logic signed [7:0] volume_max,
   input  wire logic [4:0]        volume_step,
   output logic signed [7:0]      volume_next
);

   logic signed [7:0] volume_ff;
   logic signed [9:0] vol_up, vol_dn;

   always_comb begin
      vol_up = 10'(volume_ff) + $signed({5'd0, volume_step});
      vol_dn = 10'(volume_ff) - $signed({5'd0, volume_step});
      volume_next = volume_ff;
      priority if (dir.cw) begin
         volume_next = (vol_up > 10'(volume_max)) ? volume_max : vol_up[7:0];
      end else if (dir.ccw) begin
         volume_next = (vol_dn < 10'(volume_min)) ? volume_min : vol_dn[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= VOLUME_RESET;
      end else if (update_en) begin
         volume_ff <= volume_next;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/qkvb_switch.sv
// ----------------------------------------------------------------------------
// qkvb_switch
// Push switch hold timer; classifies each release as long or short.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qkvb_switch
   import qkvb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        update_en,
   input  wire logic        switch_level,
   input  wire logic [15:0] long_press_samples,
   output press_type        press
);

   logic        switch_prev_ff;
   logic [15:0] press_count_ff, press_count_in;
   logic        release_edge;

   always_comb begin
      if (switch_prev_ff && !switch_level) begin
         press_count_in = '0;
      end else if (press_count_ff != PRESS_COUNT_MAX) begin
         press_count_in = press_count_ff + 16'd1;
      end else begin
         press_count_in = press_count_ff;
      end
      release_edge      = !switch_prev_ff && switch_level;
      press.long_press  = release_edge && (press_count_in > long_press_samples);
      press.short_press = release_edge && !(press_count_in > long_press_samples);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         switch_prev_ff <= 1'b1;
         press_count_ff <= '0;
      end else if (update_en) begin
         switch_prev_ff <= switch_level;
         press_count_ff <= press_count_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/quadrature_knob_volume_and_button.sv
// ----------------------------------------------------------------------------
// quadrature_knob_volume_and_button
// Two-knob front panel: volume knob, event knob and timed push switch.
// ----------------------------------------------------------------------------
// Flow: the input transfer loads the sample register; the sample then moves
//   into the result register, with the state update, once that register is
//   empty or its result is being transferred, and rsp_valid rises with that load.
// Throughput: one sample per cycle while the result channel does not stall, set
//   by the single-pass decode logic between the sample register and the result register.
// Reset: synchronous, active high; registers return to their reset values,
//   both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none
`include "quadrature_knob_volume_and_button_defines.svh"

module quadrature_knob_volume_and_button
   import qkvb_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   // sample channel
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   // result channel
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload,
   // register write channel
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [1:0]      csr_index,
   input  wire logic [15:0]     csr_wdata
);

   // configuration registers
   logic signed [7:0] volume_min_ff;
   logic signed [7:0] volume_max_ff;
   logic [4:0]        volume_step_ff;
   logic [15:0]       long_press_ff;

   // pipeline
   logic            stage_valid_ff;
   req_payload_type stage_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;
   logic            advance;

   knob_dir_type      knob1_dir, knob2_dir;
   logic signed [7:0] volume_next;
   press_type         press;

   // register writes are always taken; the user must send them only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_min_ff  <= VOLUME_MIN_RESET;
         volume_max_ff  <= VOLUME_MAX_RESET;
         volume_step_ff <= VOLUME_STEP_RESET;
         long_press_ff  <= LONG_PRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VOLUME_MIN:  volume_min_ff  <= csr_wdata[7:0];
            CSR_VOLUME_MAX:  volume_max_ff  <= csr_wdata[7:0];
            CSR_VOLUME_STEP: volume_step_ff <= csr_wdata[4:0];
            CSR_LONG_PRESS:  long_press_ff  <= csr_wdata;
         endcase
      end
   end

   // The sample moves into the result register when that register is empty
   // or its result is being transferred; the state update rides on the same
   // edge, so the next sample always sees up-to-date state.
   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_ff <= req_payload;
      end
   end

   // decode units
   qkvb_knob u_knob1 (
      .clock     (clock),
      .reset     (reset),
      .update_en (advance),
      .phase     ({stage_ff.knob1_phase_a, stage_ff.knob1_phase_b}),
      .dir       (knob1_dir)
   );

   qkvb_knob u_knob2 (
      .clock     (clock),
      .reset     (reset),
      .update_en (advance),
      .phase     ({stage_ff.knob2_phase_a, stage_ff.knob2_phase_b}),
      .dir       (knob2_dir)
   );

   qkvb_volume u_volume (
      .clock       (clock),
      .reset       (reset),
      .update_en   (advance),
      .dir         (knob1_dir),
      .volume_min  (volume_min_ff),
      .volume_max  (volume_max_ff),
      .volume_step (volume_step_ff),
      .volume_next (volume_next)
   );

   qkvb_switch u_switch (
      .clock              (clock),
      .reset              (reset),
      .update_en          (advance),
      .switch_level       (stage_ff.switch_level),
      .long_press_samples (long_press_ff),
      .press              (press)
   );

   // result assembly
   always_comb begin
      rsp_in.volume_changed = knob1_dir.cw || knob1_dir.ccw;
      rsp_in.volume_level   = volume_next;
      priority if (knob2_dir.cw) begin
         rsp_in.knob2_event = EVENT_CW;
      end else if (knob2_dir.ccw) begin
         rsp_in.knob2_event = EVENT_CCW;
      end else begin
         rsp_in.knob2_event = EVENT_NONE;
      end
      rsp_in.long_press  = press.long_press;
      rsp_in.short_press = press.short_press;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   `QKVB_ASSERT_IMPL(a_event_code, rsp_valid_ff, rsp_ff.knob2_event <= EVENT_CCW)
   `QKVB_ASSERT_IMPL(a_press_excl, rsp_valid_ff, !(rsp_ff.long_press && rsp_ff.short_press))
   `QKVB_ASSERT_NEXT(a_stage_hold, stage_valid_ff && !advance, stage_valid_ff)
   `QKVB_ASSERT_NEXT(a_advance_fills, advance, rsp_valid_ff)

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-knob front panel: it drives quadrature
// phase and switch samples, predicts every result transfer in step with the
// accepted samples and compares each result field by field, across several
// register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import qkvb_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on any channel
   localparam int DRAIN_CYCLES   = 6;     // two-stage pipe, plus margin
   localparam int PHASE_SAMPLES  = 200;
   localparam int MAX_REPORTS    = 10;
   localparam int HOLD_SAMPLES   = 40;    // one hold well past the last threshold
   localparam int NUM_PHASES     = 9;
   localparam int PRESS_CAP      = 400;   // cap on the threshold used for random hold lengths, in samples

   // ------------------------------------------------------------------------
   // clock, reset, DUT ports
   // ------------------------------------------------------------------------
   logic            clock = 1'b0;
   logic            reset = 1'b1;

   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;

   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_index = '0;
   logic [15:0]     csr_wdata = '0;

   quadrature_knob_volume_and_button u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // shared bench state
   // ------------------------------------------------------------------------
   req_payload_type pending_samples [$];
   rsp_payload_type expected_reports [$];

   // set at the rising edge by the monitor, read at the falling edge
   bit sample_taken = 1'b0;
   bit csr_taken    = 1'b0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   int mismatch_count = 0;
   int idle_cycles    = 0;
   int n_samples      = 0;
   int n_writes       = 0;
   int n_vol_detents  = 0;
   int n_knob2_events = 0;
   int n_long         = 0;
   int n_short        = 0;

   // ------------------------------------------------------------------------
   // panel predictor: register copy and state, updated per accepted transfer
   // ------------------------------------------------------------------------
   int         cfg_vol_min;
   int         cfg_vol_max;
   int         cfg_step;
   int         cfg_long;

   logic [1:0] knob_last  [2];
   int         knob_count [2];
   int         volume_now;
   logic       switch_last;
   int         hold_count;

   // quarter-step movement for a {previous, current} phase code pair;
   // a change of both phases at once counts as no movement
   function automatic int quad_delta(input logic [1:0] prev, input logic [1:0] cur);
      int d;
      case ({prev, cur})
         4'b0010, 4'b1011, 4'b1101, 4'b0100: d = 1;
         4'b0001, 4'b0111, 4'b1110, 4'b1000: d = -1;
         default:                            d = 0;
      endcase
      return d;
   endfunction

   // returns +1 on a clockwise detent, -1 counterclockwise, 0 otherwise
   function automatic int knob_detent(input int k, input logic [1:0] cur);
      int dir;
      dir = 0;
      knob_count[k] = knob_count[k] + quad_delta(knob_last[k], cur);
      if (knob_count[k] >= DETENT_COUNT) begin
         dir = 1;
         knob_count[k] = 0;
      end
      if (knob_count[k] <= -DETENT_COUNT) begin
         dir = -1;
         knob_count[k] = 0;
      end
      knob_last[k] = cur;
      return dir;
   endfunction

   function automatic rsp_payload_type compute_panel_report(input req_payload_type s);
      rsp_payload_type r;
      int              d1;
      int              d2;
      int              v;
      r  = '0;
      d1 = knob_detent(0, {s.knob1_phase_a, s.knob1_phase_b});
      // only the limit in the direction of travel applies
      if (d1 > 0) begin
         v = volume_now + cfg_step;
         if (v > cfg_vol_max) v = cfg_vol_max;
         volume_now = v;
         r.volume_changed = 1'b1;
      end else if (d1 < 0) begin
         v = volume_now - cfg_step;
         if (v < cfg_vol_min) v = cfg_vol_min;
         volume_now = v;
         r.volume_changed = 1'b1;
      end
      r.volume_level = volume_now[7:0];

      d2 = knob_detent(1, {s.knob2_phase_a, s.knob2_phase_b});
      if (d2 > 0)      r.knob2_event = EVENT_CW;
      else if (d2 < 0) r.knob2_event = EVENT_CCW;
      else             r.knob2_event = EVENT_NONE;

      // hold counter restarts on the press sample, saturates otherwise
      if (switch_last && !s.switch_level) hold_count = 0;
      else if (hold_count < int'(PRESS_COUNT_MAX)) hold_count++;
      if (!switch_last && s.switch_level) begin
         if (hold_count > cfg_long) r.long_press = 1'b1;
         else                       r.short_press = 1'b1;
      end
      switch_last = s.switch_level;

      n_samples++;
      if (r.volume_changed) n_vol_detents++;
      if (r.knob2_event != EVENT_NONE) n_knob2_events++;
      if (r.long_press) n_long++;
      if (r.short_press) n_short++;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   function automatic void flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t mismatch: %s", $realtime, msg);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got)
         flag_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
   endfunction

   function automatic void check_report(input rsp_payload_type want, input rsp_payload_type got);
      check_field("volume_changed", want.volume_changed, got.volume_changed);
      check_field("volume_level", $signed(want.volume_level), $signed(got.volume_level));
      check_field("knob2_event", want.knob2_event, got.knob2_event);
      check_field("long_press", want.long_press, got.long_press);
      check_field("short_press", want.short_press, got.short_press);
   endfunction

   // ------------------------------------------------------------------------
   // monitor: everything sampled at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_payload_type want;
      sample_taken = 1'b0;
      csr_taken    = 1'b0;
      if (reset) begin
         cfg_vol_min   = VOLUME_MIN_RESET;
         cfg_vol_max   = VOLUME_MAX_RESET;
         cfg_step      = VOLUME_STEP_RESET;
         cfg_long      = LONG_PRESS_RESET;
         knob_last[0]  = PHASE_RESET;
         knob_last[1]  = PHASE_RESET;
         knob_count[0] = 0;
         knob_count[1] = 0;
         volume_now    = VOLUME_RESET;
         switch_last   = 1'b1;
         hold_count    = 0;
         idle_cycles   = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            csr_taken = 1'b1;
            n_writes++;
            case (csr_index)
               CSR_VOLUME_MIN:  cfg_vol_min = $signed(csr_wdata[7:0]);
               CSR_VOLUME_MAX:  cfg_vol_max = $signed(csr_wdata[7:0]);
               CSR_VOLUME_STEP: cfg_step    = csr_wdata[4:0];
               CSR_LONG_PRESS:  cfg_long    = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            sample_taken = 1'b1;
            expected_reports.push_back(compute_panel_report(req_payload));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               flag_mismatch("result transfer with nothing expected");
            end else begin
               want = expected_reports.pop_front();
               check_report(want, rsp_payload);
            end
         end
         // watchdog: any transfer on any channel counts as progress
         if (csr_taken || sample_taken || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // drivers: inputs change at the falling edge only
   // ------------------------------------------------------------------------
   // sample sender: holds valid and payload until the transfer is seen
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || sample_taken) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending_samples.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: random back-pressure
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else       rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------------
   // stimulus generator: knobs walk the Gray sequence, switch holds
   // ------------------------------------------------------------------------
   int   gen_pos [2];
   int   gen_dir [2];
   logic gen_sw;
   int   gen_sw_left;
   int   gen_threshold;

   // clockwise order of {A, B}: 00, 10, 11, 01
   function automatic logic [1:0] phase_code(input int pos);
      logic [1:0] c;
      case (pos)
         0:       c = 2'b00;
         1:       c = 2'b10;
         2:       c = 2'b11;
         default: c = 2'b01;
      endcase
      return c;
   endfunction

   // mostly steady rotation, with reversals, jitter, double steps and noise
   function automatic logic [1:0] move_knob(input int k);
      int r;
      r = $urandom_range(99);
      if (r < 8) gen_dir[k] = -gen_dir[k];
      if (r < 50)      gen_pos[k] = gen_pos[k] + gen_dir[k];
      else if (r < 60) gen_pos[k] = gen_pos[k] + 2;          // both phases flip
      else if (r < 64) gen_pos[k] = $urandom_range(3);
      gen_pos[k] = (gen_pos[k] + 4) % 4;
      return phase_code(gen_pos[k]);
   endfunction

   function automatic req_payload_type next_sample();
      req_payload_type s;
      logic [1:0]      c1;
      logic [1:0]      c2;
      int              cap;
      c1 = move_knob(0);
      c2 = move_knob(1);
      if (gen_sw_left == 0) begin
         gen_sw = !gen_sw;
         if (gen_sw) begin
            gen_sw_left = $urandom_range(1, 12);
         end else begin
            // press lengths cluster on the long/short boundary
            cap = (gen_threshold > PRESS_CAP) ? PRESS_CAP : gen_threshold;
            case ($urandom_range(3))
               0:       gen_sw_left = cap;
               1:       gen_sw_left = cap + 1;
               2:       gen_sw_left = $urandom_range(1, 8);
               default: gen_sw_left = $urandom_range(1, cap + 2);
            endcase
            if (gen_sw_left < 1) gen_sw_left = 1;
         end
      end
      gen_sw_left--;
      s.knob1_phase_a = c1[1];
      s.knob1_phase_b = c1[0];
      s.knob2_phase_a = c2[1];
      s.knob2_phase_b = c2[0];
      s.switch_level  = gen_sw;
      return s;
   endfunction

   function automatic req_payload_type build_sample(input logic [1:0] k1,
                                                    input logic [1:0] k2,
                                                    input logic sw);
      req_payload_type s;
      s.knob1_phase_a = k1[1];
      s.knob1_phase_b = k1[0];
      s.knob2_phase_a = k2[1];
      s.knob2_phase_b = k2[0];
      s.switch_level  = sw;
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // register writes, only while the panel is idle
   // ------------------------------------------------------------------------
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   // sender pauses here until every expected result has arrived
   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_valid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // upper data bits are don't-care for the narrow registers, so fill them
   task automatic set_panel(input int vmin, input int vmax, input int step, input int thr);
      write_reg(CSR_VOLUME_MIN,  {8'($urandom), 8'(vmin)});
      write_reg(CSR_VOLUME_MAX,  {8'($urandom), 8'(vmax)});
      write_reg(CSR_VOLUME_STEP, {11'($urandom), 5'(step)});
      write_reg(CSR_LONG_PRESS,  16'(thr));
      gen_threshold = thr;
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: one detent each way on both knobs, two-phase jumps,
      // a back-and-forth wiggle, short presses, all-zero and all-one samples
      send_idle_pct  = 26;
      recv_stall_pct = 52;
      pending_samples.push_back(build_sample(2'b01, 2'b10, 1'b1));
      pending_samples.push_back(build_sample(2'b00, 2'b00, 1'b0));
      pending_samples.push_back(build_sample(2'b10, 2'b01, 1'b0));
      pending_samples.push_back(build_sample(2'b11, 2'b11, 1'b1));
      pending_samples.push_back(build_sample(2'b00, 2'b00, 1'b1));
      pending_samples.push_back(build_sample(2'b11, 2'b11, 1'b0));
      pending_samples.push_back(build_sample(2'b10, 2'b01, 1'b0));
      pending_samples.push_back(build_sample(2'b00, 2'b00, 1'b0));
      pending_samples.push_back(build_sample(2'b01, 2'b10, 1'b0));
      pending_samples.push_back(build_sample(2'b11, 2'b11, 1'b1));
      pending_samples.push_back(build_sample(2'b01, 2'b01, 1'b1));
      pending_samples.push_back(build_sample(2'b11, 2'b11, 1'b1));
      pending_samples.push_back(build_sample(2'b00, 2'b00, 1'b0));
      pending_samples.push_back(build_sample(2'b11, 2'b11, 1'b1));

      // generator picks up where the directed part left both knobs (11)
      gen_pos[0]    = 2;
      gen_pos[1]    = 2;
      gen_dir[0]    = 1;
      gen_dir[1]    = -1;
      gen_sw        = 1'b1;
      gen_sw_left   = 3;
      gen_threshold = LONG_PRESS_RESET;
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         // idle pattern: sender-light first, then receiver-light, then none
         case (p / 3)
            0: begin
               send_idle_pct  = 26;
               recv_stall_pct = 52;
            end
            1: begin
               send_idle_pct  = 52;
               recv_stall_pct = 26;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase

         case (p)
            0: ; // reset settings
            1: set_panel(-128, 127, 16, 0);
            2: set_panel(-128, 127, 31, 5);
            3: set_panel(10, -10, 3, 20);       // min above max
            4: set_panel(0, 0, 0, 65535);       // zero step, presses never long
            5: set_panel(127, 127, 1, 1);
            6: set_panel(-128, -128, 7, 40);
            7: set_panel(-50, 50, 16, 350);
            default: begin
               set_panel(-20, 20, 2, 30);
               // one steady hold past the threshold, then release
               gen_sw      = 1'b0;
               gen_sw_left = HOLD_SAMPLES;
               for (int i = 0; i < HOLD_SAMPLES; i++)
                  pending_samples.push_back(next_sample());
            end
         endcase

         for (int i = 0; i < PHASE_SAMPLES; i++)
            pending_samples.push_back(next_sample());
         wait_drained();
      end

      $display("Covered %0d samples, %0d register writes, nine settings, three idle patterns.",
               n_samples, n_writes);
      $display("Volume detents %0d, knob 2 events %0d, long presses %0d, short presses %0d.",
               n_vol_detents, n_knob2_events, n_long, n_short);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
